### design/sdrt_pkg.sv
package sdrt_pkg;

  localparam int MAX_DEVICES = 16;
  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam logic signed [7:0] STRENGTH_CEIL = 8'sd127;
  localparam int NUM_W = 26;
  localparam int MAG_W = 24;
  localparam int DVS_W = 17;

  typedef enum logic [2:0] {
    ACT_UPDATED  = 3'd0,
    ACT_INSERTED = 3'd1,
    ACT_REPLACED = 3'd2,
    ACT_DROPPED  = 3'd3,
    ACT_CLEARED  = 3'd4
  } action_t;

  typedef struct packed {
    logic              command;
    logic [47:0]       device_address;
    logic signed [7:0] signal_strength;
  } in_item_t;

  typedef struct packed {
    action_t           action;
    logic [3:0]        slot;
    logic signed [7:0] average_strength;
    logic [15:0]       sightings;
    logic [4:0]        entry_count;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic signed [7:0] hit_str;
    logic [15:0]       hit_cnt;
    logic              best_found;
    logic signed [7:0] best_val;
    logic [IDX_W-1:0]  best_idx;
  } probe_t;

  typedef struct packed {
    logic              en;
    logic              clear;
    logic [IDX_W-1:0]  idx;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic [15:0]       cnt;
  } cell_wr_t;

endpackage

### design/sdrt_cell.sv
module sdrt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sdrt_pkg::IDX_W-1:0] cell_idx,
  input  logic [sdrt_pkg::CNT_W-1:0] occupied,
  input  sdrt_pkg::cell_wr_t       wr,
  input  sdrt_pkg::probe_t         probe_in,
  output sdrt_pkg::probe_t         probe_out
);
  import sdrt_pkg::*;

  logic [47:0]       addr_r;
  logic signed [7:0] str_r;
  logic [15:0]       cnt_r;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic              in_use;
  logic              hit_here;
  logic              low_here;

  assign in_use   = CNT_W'(cell_idx) < occupied;
  assign hit_here = !probe_in.hit && in_use && (addr_r == probe_in.addr);
  assign low_here = (str_r < probe_in.best_val) && (str_r < probe_in.strength);

  always_comb begin
    probe_nxt = probe_in;
    if (hit_here) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.hit_idx = cell_idx;
      probe_nxt.hit_str = str_r;
      probe_nxt.hit_cnt = cnt_r;
    end
    if (low_here) begin
      probe_nxt.best_found = 1'b1;
      probe_nxt.best_val   = str_r;
      probe_nxt.best_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      addr_r <= '0;
      str_r  <= '0;
      cnt_r  <= '0;
    end else if (wr.en && wr.idx == cell_idx) begin
      addr_r <= wr.addr;
      str_r  <= wr.strength;
      cnt_r  <= wr.cnt;
    end
  end

  assign probe_out = probe_r;

endmodule

### design/sdrt_div.sv
module sdrt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sdrt_pkg::MAG_W-1:0] dividend,
  input  logic [sdrt_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [sdrt_pkg::MAG_W-1:0] quotient
);
  import sdrt_pkg::*;

  logic [MAG_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem_r, dvd_r[MAG_W-1]};
  assign take   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'(MAG_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= take ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      dvd_r <= {dvd_r[MAG_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### design/scan_device_rssi_table_core.sv
// A clear beat is answered straight from ST_IDLE; an observe beat walks the cell
// chain in ST_SEARCH and, if the address is found, then runs ST_MUL and ST_DIV.
// The probe moves one cell per cycle; the average update adds a multiply state
// and a restoring divider. One beat is in work at a time.
// Synchronous active-low reset zeroes the table and the control state.
// The receiver cannot stall: each result is shown for one cycle on out_valid.
module scan_device_rssi_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sdrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sdrt_pkg::out_item_t out_data
);
  import sdrt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_DIV    = 4'b1000
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  logic [CNT_W-1:0]         occ_r;
  logic [CNT_W-1:0]         occ_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  out_item_t                out_r;
  out_item_t                out_nxt;
  logic [47:0]              addr_r;
  logic signed [7:0]        str_r;
  logic [IDX_W-1:0]         slot_r;
  logic [15:0]              hcnt_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [MAG_W-1:0]         num_mag;
  logic [MAG_W-1:0]         quot;
  logic                     div_done;
  logic signed [7:0]        avg;
  logic [15:0]              cnt_inc;
  cell_wr_t                 wr;
  probe_t                   probe [MAX_DEVICES+1];
  probe_t                   fin;
  logic                     accept;

  assign accept  = start && !busy;
  assign busy    = state_r != ST_IDLE;
  assign fin     = probe[MAX_DEVICES];
  assign num_mag = num_r[NUM_W-1] ? MAG_W'(-num_r) : num_r[MAG_W-1:0];
  assign avg     = num_r[NUM_W-1] ? -quot[7:0] : quot[7:0];
  assign cnt_inc = hcnt_r + 16'd1;

  always_comb begin
    probe[0]            = '0;
    probe[0].valid      = accept && !in_data.command;
    probe[0].addr       = in_data.device_address;
    probe[0].strength   = in_data.signal_strength;
    probe[0].best_val   = STRENGTH_CEIL;
  end

  for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
    sdrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .occupied  (occ_r),
      .wr        (wr),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

  sdrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_MUL),
    .dividend (num_mag),
    .divisor  (DVS_W'(hcnt_r) + DVS_W'(1)),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr            = '0;
    wr.addr       = addr_r;
    wr.strength   = str_r;
    wr.cnt        = 16'd1;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.command) begin
          wr.clear      = 1'b1;
          occ_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.action = ACT_CLEARED;
        end else if (accept) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (fin.valid) begin
          out_nxt = '0;
          if (fin.hit) begin
            state_nxt = ST_MUL;
          end else if (occ_r < CNT_W'(MAX_DEVICES)) begin
            state_nxt         = ST_IDLE;
            wr.en             = 1'b1;
            wr.idx            = occ_r[IDX_W-1:0];
            occ_nxt           = occ_r + CNT_W'(1);
            out_valid_nxt     = 1'b1;
            out_nxt.action    = ACT_INSERTED;
            out_nxt.slot      = 4'(32'(occ_r));
            out_nxt.average_strength = str_r;
            out_nxt.sightings = 16'd1;
          end else if (fin.best_found) begin
            state_nxt         = ST_IDLE;
            wr.en             = 1'b1;
            wr.idx            = fin.best_idx;
            out_valid_nxt     = 1'b1;
            out_nxt.action    = ACT_REPLACED;
            out_nxt.slot      = 4'(32'(fin.best_idx));
            out_nxt.average_strength = str_r;
            out_nxt.sightings = 16'd1;
          end else begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_nxt.action = ACT_DROPPED;
          end
          out_nxt.entry_count = 5'(32'(occ_nxt));
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt         = ST_IDLE;
          wr.en             = 1'b1;
          wr.idx            = slot_r;
          wr.strength       = avg;
          wr.cnt            = cnt_inc;
          out_valid_nxt     = 1'b1;
          out_nxt.action    = ACT_UPDATED;
          out_nxt.slot      = 4'(32'(slot_r));
          out_nxt.average_strength = avg;
          out_nxt.sightings = cnt_inc;
          out_nxt.entry_count = 5'(32'(occ_r));
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      addr_r <= in_data.device_address;
      str_r  <= in_data.signal_strength;
    end
    if (state_r == ST_SEARCH && fin.valid) begin
      slot_r <= fin.hit_idx;
      hcnt_r <= fin.hit_cnt;
      num_r  <= NUM_W'(fin.hit_str) * NUM_W'($signed({1'b0, fin.hit_cnt})) + NUM_W'(str_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a beat is still in work");
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_DEVICES))
    else $error("occupied count beyond table size");
  a_probe_search: assert property (@(posedge clk) disable iff (!rst_n)
    fin.valid |-> state_r == ST_SEARCH)
    else $error("probe left the chain outside the search");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

### tb/scan_device_rssi_table_core_tb.sv
`timescale 1ns / 1ps
module scan_device_rssi_table_core_tb;
  import sdrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  in_item_t pending_items[$];
  out_item_t expected_results[$];

  logic [47:0] tbl_addr[MAX_DEVICES];
  logic signed [7:0] tbl_avg[MAX_DEVICES];
  logic [15:0] tbl_cnt[MAX_DEVICES];
  int occupied;

  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stim_done = 0;

  always #10 clk = ~clk;

  scan_device_rssi_table_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  function automatic out_item_t observe_table(in_item_t it);
    out_item_t r;
    int idx;
    int occ_w;
    int num;
    int best_v;
    int best_i;
    bit found;
    r = '0;
    if (it.command) begin
      for (int i = 0; i < MAX_DEVICES; i++) begin
        tbl_addr[i] = '0;
        tbl_avg[i] = '0;
        tbl_cnt[i] = '0;
      end
      occupied = 0;
      r.action = ACT_CLEARED;
      return r;
    end
    for (int i = 0; i < occupied; i++) begin
      if (tbl_addr[i] == it.device_address) begin
        occ_w = int'(tbl_cnt[i]);
        num = int'(tbl_avg[i]) * occ_w + int'(it.signal_strength);
        tbl_avg[i] = 8'(num / (occ_w + 1));
        tbl_cnt[i] = tbl_cnt[i] + 16'd1;
        r.action = ACT_UPDATED;
        r.slot = 4'(i);
        r.average_strength = tbl_avg[i];
        r.sightings = tbl_cnt[i];
        r.entry_count = 5'(occupied);
        return r;
      end
    end
    idx = -1;
    if (occupied < MAX_DEVICES) begin
      idx = occupied;
      occupied++;
      r.action = ACT_INSERTED;
    end else begin
      best_v = int'(STRENGTH_CEIL);
      best_i = 0;
      found = 0;
      for (int i = 0; i < MAX_DEVICES; i++) begin
        if (int'(tbl_avg[i]) < best_v && tbl_avg[i] < it.signal_strength) begin
          best_v = int'(tbl_avg[i]);
          best_i = i;
          found = 1;
        end
      end
      if (found) begin
        idx = best_i;
        r.action = ACT_REPLACED;
      end
    end
    if (idx < 0) begin
      r.action = ACT_DROPPED;
      r.entry_count = 5'(occupied);
      return r;
    end
    tbl_addr[idx] = it.device_address;
    tbl_avg[idx] = it.signal_strength;
    tbl_cnt[idx] = 16'd1;
    r.slot = 4'(idx);
    r.average_strength = it.signal_strength;
    r.sightings = 16'd1;
    r.entry_count = 5'(occupied);
    return r;
  endfunction

  function automatic in_item_t make_item(bit cmd, logic [47:0] a, logic signed [7:0] s);
    in_item_t it;
    it.command = cmd;
    it.device_address = a;
    it.signal_strength = s;
    return it;
  endfunction

  // The driver keeps start high until the beat is taken, then waits a random gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(observe_table(in_data));
        gap_left <= $urandom_range(0, 9);
        start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (e.action !== out_data.action || e.slot !== out_data.slot ||
            e.average_strength !== out_data.average_strength ||
            e.sightings !== out_data.sightings || e.entry_count !== out_data.entry_count) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [47:0] pool[8];
    logic [47:0] a;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      tbl_addr[i] = '0;
      tbl_avg[i] = '0;
      tbl_cnt[i] = '0;
    end
    occupied = 0;
    for (int i = 0; i < 8; i++) pool[i] = 48'({$urandom, $urandom});
    // Directed: extremes, fill to full, replacement, drop and clear.
    pending_items.push_back(make_item(1'b0, 48'h0, -8'sd128));
    pending_items.push_back(make_item(1'b0, 48'h0, 8'sd127));
    pending_items.push_back(make_item(1'b0, 48'hFFFF_FFFF_FFFF, 8'sd127));
    pending_items.push_back(make_item(1'b0, 48'hFFFF_FFFF_FFFF, -8'sd128));
    pending_items.push_back(make_item(1'b0, 48'hAAAA_AAAA_AAAA, -8'sd1));
    pending_items.push_back(make_item(1'b0, 48'h5555_5555_5555, 8'sd1));
    for (int i = 0; i < 12; i++) pending_items.push_back(make_item(1'b0, 48'(i + 16), -8'sd100));
    pending_items.push_back(make_item(1'b0, 48'h1234, -8'sd100));
    pending_items.push_back(make_item(1'b0, 48'h1235, -8'sd50));
    pending_items.push_back(make_item(1'b0, 48'h1236, -8'sd128));
    pending_items.push_back(make_item(1'b1, 48'hFFFF_FFFF_FFFF, -8'sd1));
    pending_items.push_back(make_item(1'b0, 48'h0, 8'sd0));
    // Random: reuse a small address pool so hits, inserts, replaces and drops all occur.
    for (int n = 0; n < 376; n++) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 2) begin
        pending_items.push_back(make_item(1'b1, 48'({$urandom, $urandom}), 8'($urandom)));
      end else begin
        if (k < 55) a = pool[$urandom_range(0, 7)];
        else if (k < 80) a = 48'($urandom_range(0, 23));
        else a = 48'({$urandom, $urandom});
        pending_items.push_back(make_item(1'b0, a, 8'($urandom)));
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
